// File: rtl/sbpq_pkg.sv
// sbpq_pkg: shared types and codes for the sorted byte priority queue.
// Used by sbpq_list and sorted_byte_priority_queue; depends on nothing.
package sbpq_pkg;

    localparam int KEY_W  = 8;
    localparam int FILL_W = 5;
    localparam int STAT_W = 2;

    // command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [KEY_W-1:0] t_key;

    // one result beat as produced by the list
    typedef struct packed {
        t_key              out_key;
        logic              out_valid;
        logic [FILL_W-1:0] fill;
        logic [STAT_W-1:0] status;
    } t_res;

endpackage

// File: rtl/sbpq_list.sv
// sbpq_list: register array of keys kept in descending order plus the count.
// Depends on sbpq_pkg. Applies one enqueue or dequeue per cycle.
module sbpq_list
    import sbpq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  logic i_cmd,
    input  t_key i_key,
    output t_res o_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // largest key sits at entry 0
    t_key             r_keys [CAPACITY];
    t_key             n_keys [CAPACITY];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CAPACITY-1:0] ge;
    logic             is_full;
    logic             is_empty;
    logic [CNT_W+FILL_W-1:0] fill_ext;

    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);

    // compare the new key against every stored entry at once
    always_comb begin
        for (int j = 0; j < CAPACITY; j++) begin
            ge[j] = (CNT_W'(j) < r_count) && (r_keys[j] >= i_key);
        end
    end

    // build next array, count and the result beat
    always_comb begin
        n_count         = r_count;
        o_res.out_key   = '0;
        o_res.out_valid = 1'b0;
        o_res.status    = ST_OK;
        for (int j = 0; j < CAPACITY; j++) begin
            n_keys[j] = r_keys[j];
        end
        if (i_cmd == CMD_ENQ) begin
            if (is_full) begin
                o_res.status = ST_FULL;
            end else begin
                // keep entries >= key, drop key in, shift the rest down
                for (int j = 0; j < CAPACITY; j++) begin
                    if (ge[j]) begin
                        n_keys[j] = r_keys[j];
                    end else if (j == 0) begin
                        n_keys[j] = i_key;
                    end else if (ge[j-1]) begin
                        n_keys[j] = i_key;
                    end else begin
                        n_keys[j] = r_keys[j-1];
                    end
                end
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (is_empty) begin
                o_res.status = ST_EMPTY;
            end else begin
                // pop the head, advance everything up one place
                o_res.out_key   = r_keys[0];
                o_res.out_valid = 1'b1;
                for (int j = 0; j < CAPACITY - 1; j++) begin
                    n_keys[j] = r_keys[j+1];
                end
                n_count = r_count - CNT_W'(1);
            end
        end
        fill_ext   = {{FILL_W{1'b0}}, n_count};
        o_res.fill = fill_ext[FILL_W-1:0];
    end

    // clear count under reset, update it on each valid beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_vld) begin
            r_count <= n_count;
        end
    end

    // key storage needs no reset
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            for (int j = 0; j < CAPACITY; j++) begin
                r_keys[j] <= n_keys[j];
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (r_keys[0] >= r_keys[1]))
        else $error("head entries out of order");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && i_cmd == CMD_ENQ && is_full) |=> $stable(r_count))
        else $error("refused enqueue changed the count");

    a_deq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && i_cmd == CMD_DEQ && !is_empty) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("dequeue did not drop the count by one");

endmodule

// File: rtl/sorted_byte_priority_queue.sv
// sorted_byte_priority_queue: top level, input and result registers around sbpq_list.
// Depends on sbpq_pkg and sbpq_list.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  command  | in        | start high, busy low    | i_cmd, i_key
//  result   | out       | o_done for one cycle    | o_out_key, o_out_valid, o_fill, o_status
//
// One command beat per cycle while busy is low; its result passes the input register,
// then the list update and result register, before it shows with o_done.
// busy is high during reset and in the cycle after it; it never rises afterwards.
// Reset empties the queue; stored keys are left as they were.
// The result side cannot stall: o_done pulses once per accepted beat.
module sorted_byte_priority_queue
    import sbpq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cmd,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_done,
    output logic [KEY_W-1:0]  o_out_key,
    output logic              o_out_valid,
    output logic [FILL_W-1:0] o_fill,
    output logic [STAT_W-1:0] o_status
);

    logic r_busy;
    logic r_req_vld;
    logic r_cmd;
    t_key r_key;
    logic r_done;
    t_res r_res;
    t_res list_res;

    // capture the command beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_req_vld <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_req_vld <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= i_cmd;
        r_key <= i_key;
    end

    sbpq_list #(
        .CAPACITY (CAPACITY)
    ) u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_req_vld),
        .i_cmd   (r_cmd),
        .i_key   (r_key),
        .o_res   (list_res)
    );

    // register the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= list_res;
    end

    assign busy        = r_busy;
    assign o_done      = r_done;
    assign o_out_key   = r_res.out_key;
    assign o_out_valid = r_res.out_valid;
    assign o_fill      = r_res.fill;
    assign o_status    = r_res.status;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("accepted beat gave no result two cycles later");

    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_valid) |-> (o_status == ST_OK))
        else $error("dequeued key reported with error status");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without an accepted beat");

endmodule
